// ===== src/prc_pkg.sv =====
// Package for the presence relay controller: types, codes and scaling constants.
`timescale 1ns / 1ps
package prc_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ECHO,
    S_DIST,
    S_CUR,
    S_CDIV,
    S_VOLT,
    S_VMUL,
    S_VDIV,
    S_PWR,
    S_PDIV,
    S_DONE
  } seq_state_t;

  // register indexes on the APB port (byte address / 4)
  localparam logic [2:0] REG_ACT_DIST = 3'd0;
  localparam logic [2:0] REG_ACT_TIME = 3'd1;
  localparam logic [2:0] REG_OFF_TIME = 3'd2;
  localparam logic [2:0] REG_OT_THR   = 3'd3;
  localparam logic [2:0] REG_MAX_PWR  = 3'd4;
  localparam logic [2:0] REG_CUR_GAIN = 3'd5;
  localparam logic [2:0] REG_CUR_DZ   = 3'd6;

  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_TEMP  = 2'd1;
  localparam logic [1:0] FAULT_POWER = 2'd2;

  // operand constants for the shared multiplier
  localparam logic [31:0] K_ECHO     = 32'd343;
  localparam logic [31:0] K_VOLT     = 32'd7950;
  localparam logic [31:0] K_VOFS     = 32'd28453;
  localparam logic [31:0] K_RMS      = 32'd707;

  // round-up reciprocals: floor(x*M >> S) == floor(x/D) exactly for the operand ranges used
  localparam logic [31:0] M_D20000   = 32'd54975582;
  localparam int          S_D20000   = 40;
  localparam logic [31:0] M_D1000    = 32'd549755814;
  localparam int          S_D1000    = 39;
  localparam logic [31:0] M_D100000  = 32'd43980466;
  localparam int          S_D100000  = 42;
  localparam logic [31:0] M_D100     = 32'd10737419;
  localparam int          S_D100     = 30;

  localparam logic [13:0] CENT_MAX   = 14'd16383;
  localparam logic [8:0]  VOLT_MAX   = 9'd511;
  localparam logic [15:0] WATT_MAX   = 16'd65535;

  // result tdata layout
  localparam int OUT_RELAY     = 0;
  localparam int OUT_DIST_LSB  = 1;
  localparam int OUT_CENT_LSB  = 12;
  localparam int OUT_VOLT_LSB  = 26;
  localparam int OUT_WATT_LSB  = 35;
  localparam int OUT_FAULT_LSB = 51;
  localparam int OUT_W         = 56;

  typedef struct packed {
    logic [10:0] act_dist;
    logic [15:0] act_time;
    logic [15:0] off_time;
    logic [9:0]  ot_thr;
    logic [15:0] max_power;
  } relay_cfg_t;

  typedef struct packed {
    logic [10:0] distance;
    logic [15:0] watts;
    logic [9:0]  reg_temp;
    logic [9:0]  relay_temp;
    logic [31:0] now;
    logic        manual;
  } relay_meas_t;

endpackage

// ===== src/prc_mul.sv =====
// Shared 32x32 unsigned multiplier with registered product.
`timescale 1ns / 1ps
module prc_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  always_ff @(posedge clk) begin
    if (en) begin
      p <= 64'(a) * 64'(b);
    end
  end

endmodule

// ===== src/prc_relay.sv =====
// Relay timers, presence/absence logic and trip handling.
`timescale 1ns / 1ps
module prc_relay import prc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        commit,
  input  relay_cfg_t  cfg,
  input  relay_meas_t meas,
  output logic        relay_on,
  output logic [1:0]  fault
);

  logic        presence_pending, presence_pending_next;
  logic [31:0] presence_start, presence_start_next;
  logic        absence_armed, absence_armed_next;
  logic [31:0] absence_start, absence_start_next;
  logic        relay_state, relay_state_next;

  always_comb begin
    logic [31:0] p_elapsed;
    logic [31:0] a_elapsed;
    logic        hot;
    presence_pending_next = presence_pending;
    presence_start_next   = presence_start;
    absence_armed_next    = absence_armed;
    absence_start_next    = absence_start;
    relay_state_next      = relay_state;
    fault                 = FAULT_NONE;

    if (meas.distance < cfg.act_dist) begin
      if (!presence_pending && !relay_state) begin
        presence_start_next   = meas.now;
        presence_pending_next = 1'b1;
      end
    end else begin
      presence_start_next = meas.now;
      if (relay_state && !absence_armed) begin
        absence_start_next = meas.now;
        absence_armed_next = 1'b1;
      end
    end

    p_elapsed = meas.now - presence_start_next;
    if (presence_pending_next && (p_elapsed > 32'(cfg.act_time))) begin
      relay_state_next      = 1'b1;
      presence_pending_next = 1'b0;
      presence_start_next   = meas.now;
      absence_armed_next    = 1'b0;
    end

    a_elapsed = meas.now - absence_start_next;
    if (absence_armed_next && (a_elapsed > 32'(cfg.off_time)) && !meas.manual) begin
      absence_armed_next = 1'b0;
      relay_state_next   = 1'b0;
    end

    // overtemperature checked first; overload cannot override it once relay is off
    hot = (meas.relay_temp > cfg.ot_thr) || (meas.reg_temp > cfg.ot_thr);
    if (hot && relay_state_next) begin
      relay_state_next = 1'b0;
      fault            = FAULT_TEMP;
    end
    if ((meas.watts > cfg.max_power) && relay_state_next) begin
      relay_state_next = 1'b0;
      fault            = FAULT_POWER;
    end
  end

  assign relay_on = relay_state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      presence_pending <= 1'b0;
      presence_start   <= '0;
      absence_armed    <= 1'b0;
      absence_start    <= '0;
      relay_state      <= 1'b0;
    end else if (commit) begin
      presence_pending <= presence_pending_next;
      presence_start   <= presence_start_next;
      absence_armed    <= absence_armed_next;
      absence_start    <= absence_start_next;
      relay_state      <= relay_state_next;
    end
  end

endmodule

// ===== src/presence_relay_controller.sv =====
// Presence relay controller top level: APB registers, sequencer and result register.
// Each item takes 9 multiply steps on the shared 32x32 multiplier, then a finishing
// step that loads the output register.
// Input is accepted only in the idle state, so a new item waits until the last is done;
// a waiting result holds the sequencer in the finishing step and blocks input.
// Reset: synchronous, active high; registers return to defaults, timers and relay clear.
`timescale 1ns / 1ps
module presence_relay_controller import prc_pkg::*; #(
  parameter int ADC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  // s_tdata from bit 0: echo_count(16), current_code(ADC_BITS), voltage_code(ADC_BITS),
  // regulator_temp(10), relay_temp(10), time_ms(32), manual_mode(1), zero pad
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [((69 + 2 * ADC_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // m_tdata from bit 0: relay_on(1), distance_cm(11), current_centiamps(14),
  // voltage_volts(9), power_watts(16), fault(2), zero pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int OFS_RT  = 16 + 2 * ADC_BITS;

  // configuration registers
  logic [10:0] act_dist;
  logic [15:0] act_time;
  logic [15:0] off_time;
  logic [9:0]  ot_thr;
  logic [15:0] max_power;
  logic [12:0] cur_gain;
  logic [9:0]  cur_dz;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      act_dist  <= 11'd60;
      act_time  <= 16'd1500;
      off_time  <= 16'd15000;
      ot_thr    <= 10'd70;
      max_power <= 16'd1000;
      cur_gain  <= 13'd3846;
      cur_dz    <= 10'd18;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_ACT_DIST: act_dist  <= pwdata[10:0];
        REG_ACT_TIME: act_time  <= pwdata[15:0];
        REG_OFF_TIME: off_time  <= pwdata[15:0];
        REG_OT_THR:   ot_thr    <= pwdata[9:0];
        REG_MAX_PWR:  max_power <= pwdata[15:0];
        REG_CUR_GAIN: cur_gain  <= pwdata[12:0];
        REG_CUR_DZ:   cur_dz    <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACT_DIST: prdata = 32'(act_dist);
      REG_ACT_TIME: prdata = 32'(act_time);
      REG_OFF_TIME: prdata = 32'(off_time);
      REG_OT_THR:   prdata = 32'(ot_thr);
      REG_MAX_PWR:  prdata = 32'(max_power);
      REG_CUR_GAIN: prdata = 32'(cur_gain);
      REG_CUR_DZ:   prdata = 32'(cur_dz);
      default:      prdata = '0;
    endcase
  end

  // sequencer
  seq_state_t state, state_next;
  logic       in_accept;
  logic       commit;

  assign s_tready  = (state == S_IDLE) && !rst;
  assign in_accept = s_tvalid && s_tready;
  assign commit    = (state == S_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_accept) state_next = S_ECHO;
      S_ECHO: state_next = S_DIST;
      S_DIST: state_next = S_CUR;
      S_CUR:  state_next = S_CDIV;
      S_CDIV: state_next = S_VOLT;
      S_VOLT: state_next = S_VMUL;
      S_VMUL: state_next = S_VDIV;
      S_VDIV: state_next = S_PWR;
      S_PWR:  state_next = S_PDIV;
      S_PDIV: state_next = S_DONE;
      S_DONE: if (commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // latched item
  logic [15:0]         echo;
  logic [ADC_BITS-1:0] icode;
  logic [ADC_BITS-1:0] vcode;
  logic [9:0]          reg_temp;
  logic [9:0]          relay_temp;
  logic [31:0]         now;
  logic                manual;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      echo       <= s_tdata[15:0];
      icode      <= s_tdata[16 +: ADC_BITS];
      vcode      <= s_tdata[16 + ADC_BITS +: ADC_BITS];
      reg_temp   <= s_tdata[OFS_RT +: 10];
      relay_temp <= s_tdata[OFS_RT + 10 +: 10];
      now        <= s_tdata[OFS_RT + 20 +: 32];
      manual     <= s_tdata[OFS_RT + 52];
    end
  end

  // shared multiplier
  logic        mul_en;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  prc_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // values pulled off the product register in the step after each multiply
  logic [10:0] prev_dist;
  logic [10:0] distance;
  logic [13:0] cent;
  logic [8:0]  volts;
  logic [10:0] dist_quot;
  logic [11:0] dist_sum;
  logic [24:0] cent_raw;
  logic [13:0] cent_sat;
  logic [21:0] volt_raw;
  logic [8:0]  volt_sat;
  logic [33:0] watt_raw;
  logic [15:0] watt_sat;

  assign dist_quot = 11'(prod >> S_D20000);
  assign dist_sum  = {1'b0, dist_quot} + {1'b0, prev_dist};
  assign cent_raw  = 25'(prod >> S_D1000);
  assign cent_sat  = (cent_raw > 25'(CENT_MAX)) ? CENT_MAX : cent_raw[13:0];
  assign volt_raw  = 22'(prod >> S_D100000);
  assign volt_sat  = (volt_raw > 22'(VOLT_MAX)) ? VOLT_MAX : volt_raw[8:0];
  assign watt_raw  = 34'(prod >> S_D100);
  assign watt_sat  = (watt_raw > 34'(WATT_MAX)) ? WATT_MAX : watt_raw[15:0];

  always_comb begin
    mul_en = 1'b1;
    mul_a  = prod[31:0];
    mul_b  = '0;
    unique case (state)
      S_ECHO: begin
        mul_a = 32'(echo);
        mul_b = K_ECHO;
      end
      S_DIST: mul_b = M_D20000;
      S_CUR: begin
        mul_a = 32'(icode);
        mul_b = 32'(cur_gain);
      end
      S_CDIV: mul_b = M_D1000;
      S_VOLT: begin
        mul_a = 32'(vcode);
        mul_b = K_VOLT;
      end
      S_VMUL: begin
        mul_a = (prod[31:0] >> ADC_BITS) + K_VOFS;
        mul_b = K_RMS;
      end
      S_VDIV: mul_b = M_D100000;
      S_PWR: begin
        mul_a = 32'(volt_sat);
        mul_b = 32'(cent);
      end
      S_PDIV: mul_b = M_D100;
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_dist <= '0;
    end else if (state == S_CUR) begin
      prev_dist <= dist_sum[11:1];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CUR) begin
      distance <= dist_sum[11:1];
    end
    if (state == S_VOLT) begin
      cent <= (cent_sat < 14'(cur_dz)) ? 14'd0 : cent_sat;
    end
    if (state == S_PWR) begin
      volts <= volt_sat;
    end
  end

  // relay decision
  relay_cfg_t  rcfg;
  relay_meas_t rmeas;
  logic        relay_on;
  logic [1:0]  fault;

  assign rcfg  = '{act_dist: act_dist, act_time: act_time, off_time: off_time,
                   ot_thr: ot_thr, max_power: max_power};
  assign rmeas = '{distance: distance, watts: watt_sat, reg_temp: reg_temp,
                   relay_temp: relay_temp, now: now, manual: manual};

  prc_relay u_relay (
    .clk      (clk),
    .rst      (rst),
    .commit   (commit),
    .cfg      (rcfg),
    .meas     (rmeas),
    .relay_on (relay_on),
    .fault    (fault)
  );

  // result register
  logic [OUT_W-1:0] result_word;

  always_comb begin
    result_word                        = '0;
    result_word[OUT_RELAY]             = relay_on;
    result_word[OUT_DIST_LSB +: 11]    = distance;
    result_word[OUT_CENT_LSB +: 14]    = cent;
    result_word[OUT_VOLT_LSB +: 9]     = volts;
    result_word[OUT_WATT_LSB +: 16]    = watt_sat;
    result_word[OUT_FAULT_LSB +: 2]    = fault;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= result_word;
    end
  end

endmodule

// ===== src/prc_checker.sv =====
// Port-level checks for the presence relay controller, bound to the top level.
`timescale 1ns / 1ps
module prc_checker import prc_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  // one item at a time: busy right after an input transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while previous item in progress");

  // a tripped pass always leaves the relay off
  a_fault_relay_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[OUT_FAULT_LSB +: 2] != FAULT_NONE) |-> !m_tdata[OUT_RELAY])
    else $error("fault reported with relay on");

  a_fault_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_FAULT_LSB +: 2] != 2'd3))
    else $error("undefined fault code");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind presence_relay_controller prc_checker u_prc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
